@@ hdl/krs_pkg.sv @@
package krs_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_DELETE = 3'd1;
	localparam logic [2:0] ACT_UPDATE = 3'd2;
	localparam logic [2:0] ACT_LOOKUP = 3'd3;
	localparam logic [2:0] ACT_LIST   = 3'd4;

	localparam logic [1:0] RC_OK        = 2'd0;
	localparam logic [1:0] RC_FULL      = 2'd1;
	localparam logic [1:0] RC_EMPTY     = 2'd2;
	localparam logic [1:0] RC_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] order_id;
		logic [15:0] quantity;
		logic [1:0]  status_code;
		logic [31:0] customer_ref;
		logic [31:0] dish_ref;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic        has_record;
		logic [31:0] out_id;
		logic [15:0] out_quantity;
		logic [1:0]  out_status;
		logic [31:0] out_customer_ref;
		logic [31:0] out_dish_ref;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] quantity;
		logic [1:0]  status;
		logic [31:0] customer_ref;
		logic [31:0] dish_ref;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_SHIFT,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		RD_TOP,
		RD_NEXT,
		RD_HOLD,
		RD_ABOVE,
		RD_SHIFT
	} rd_sel_t;

	typedef enum logic {
		OUT_PLAIN,
		OUT_PEND
	} out_sel_t;

	typedef struct packed {
		logic       accept;
		rd_sel_t    rd_sel;
		logic       load_idx;
		logic       dec_idx;
		logic       clr_hit;
		logic       wr_insert;
		logic       wr_update;
		logic       wr_shift;
		logic       inc_fill;
		logic       dec_fill;
		logic       set_sidx;
		logic       inc_sidx;
		logic       load_pend;
		logic       clr_pend;
		logic       code_load;
		logic [1:0] code;
		logic       out_load;
		out_sel_t   out_sel;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       empty;
		logic       full;
		logic       match;
		logic       idx_zero;
		logic       at_top;
		logic       shift_last;
		logic       hit;
		logic       pend_valid;
		logic       out_free;
	} sts_t;

endpackage

@@ hdl/krs_ram.sv @@
module krs_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/krs_ctrl.sv @@
module krs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  krs_pkg::sts_t sts,
	output krs_pkg::cmd_t cmd
);

	krs_pkg::state_t state_q;
	krs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = krs_pkg::RD_HOLD;
		cmd.out_sel = krs_pkg::OUT_PLAIN;
		req_stall = (state_q != krs_pkg::ST_IDLE);

		case (state_q)
			krs_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d = krs_pkg::ST_DECIDE;
				end
			end

			krs_pkg::ST_DECIDE: begin
				case (sts.action)
					krs_pkg::ACT_INSERT: begin
						cmd.code_load = 1'b1;
						if (sts.full) begin
							cmd.code = krs_pkg::RC_FULL;
						end else begin
							cmd.code = krs_pkg::RC_OK;
							cmd.wr_insert = 1'b1;
							cmd.inc_fill = 1'b1;
						end
						state_d = krs_pkg::ST_EMIT;
					end
					krs_pkg::ACT_DELETE, krs_pkg::ACT_UPDATE,
					krs_pkg::ACT_LOOKUP, krs_pkg::ACT_LIST: begin
						if (sts.empty) begin
							cmd.code_load = 1'b1;
							if (sts.action inside {krs_pkg::ACT_DELETE, krs_pkg::ACT_LIST}) begin
								cmd.code = krs_pkg::RC_EMPTY;
							end else begin
								cmd.code = krs_pkg::RC_NOT_FOUND;
							end
							state_d = krs_pkg::ST_EMIT;
						end else begin
							cmd.load_idx = 1'b1;
							cmd.clr_hit = 1'b1;
							cmd.rd_sel = krs_pkg::RD_TOP;
							state_d = krs_pkg::ST_SCAN;
						end
					end
					default: begin
						state_d = krs_pkg::ST_IDLE;
					end
				endcase
			end

			krs_pkg::ST_SCAN: begin
				case (sts.action)
					krs_pkg::ACT_UPDATE: begin
						cmd.wr_update = sts.match;
						if (sts.idx_zero) begin
							cmd.code_load = 1'b1;
							cmd.code = (sts.hit || sts.match) ? krs_pkg::RC_OK
								: krs_pkg::RC_NOT_FOUND;
							state_d = krs_pkg::ST_EMIT;
						end else begin
							cmd.dec_idx = 1'b1;
							cmd.rd_sel = krs_pkg::RD_NEXT;
						end
					end
					krs_pkg::ACT_DELETE: begin
						if (sts.match) begin
							cmd.load_pend = 1'b1;
							cmd.dec_fill = 1'b1;
							if (sts.at_top) begin
								state_d = krs_pkg::ST_FLUSH;
							end else begin
								cmd.set_sidx = 1'b1;
								cmd.rd_sel = krs_pkg::RD_ABOVE;
								state_d = krs_pkg::ST_SHIFT;
							end
						end else if (sts.idx_zero) begin
							cmd.code_load = 1'b1;
							cmd.code = krs_pkg::RC_NOT_FOUND;
							state_d = krs_pkg::ST_EMIT;
						end else begin
							cmd.dec_idx = 1'b1;
							cmd.rd_sel = krs_pkg::RD_NEXT;
						end
					end
					default: begin
						// lookup and list: hold one match back so the final one gets last
						if (sts.match && sts.pend_valid && !sts.out_free) begin
							cmd.rd_sel = krs_pkg::RD_HOLD;
						end else begin
							if (sts.match) begin
								cmd.load_pend = 1'b1;
								if (sts.pend_valid) begin
									cmd.out_load = 1'b1;
									cmd.out_sel = krs_pkg::OUT_PEND;
								end
							end
							if (sts.idx_zero) begin
								if (sts.pend_valid || sts.match) begin
									state_d = krs_pkg::ST_FLUSH;
								end else begin
									cmd.code_load = 1'b1;
									cmd.code = krs_pkg::RC_NOT_FOUND;
									state_d = krs_pkg::ST_EMIT;
								end
							end else begin
								cmd.dec_idx = 1'b1;
								cmd.rd_sel = krs_pkg::RD_NEXT;
							end
						end
					end
				endcase
			end

			krs_pkg::ST_SHIFT: begin
				cmd.wr_shift = 1'b1;
				if (sts.shift_last) begin
					state_d = krs_pkg::ST_FLUSH;
				end else begin
					cmd.inc_sidx = 1'b1;
					cmd.rd_sel = krs_pkg::RD_SHIFT;
				end
			end

			krs_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = krs_pkg::OUT_PLAIN;
					cmd.out_last = 1'b1;
					state_d = krs_pkg::ST_IDLE;
				end
			end

			krs_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel = krs_pkg::OUT_PEND;
					cmd.out_last = 1'b1;
					cmd.clr_pend = 1'b1;
					state_d = krs_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = krs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/krs_dp.sv @@
module krs_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  krs_pkg::req_t req_data,
	input  logic          rsp_stall,
	output logic          rsp_valid,
	output krs_pkg::rsp_t rsp_data,
	input  krs_pkg::cmd_t cmd,
	output krs_pkg::sts_t sts
);

	localparam int IDX_W = krs_pkg::IDX_W;
	localparam int CNT_W = krs_pkg::CNT_W;

	krs_pkg::req_t      item_q;
	krs_pkg::rec_t      pend_q;
	krs_pkg::rsp_t      out_q;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   sidx_q;
	logic [1:0]         code_q;
	logic               hit_q;
	logic               pend_valid_q;
	logic               out_valid_q;

	krs_pkg::rec_t      rd_rec;
	krs_pkg::rec_t      wr_rec;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [IDX_W-1:0]   ram_raddr;
	logic               out_free;

	krs_ram #(
		.W     ($bits(krs_pkg::rec_t)),
		.DEPTH (krs_pkg::STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_rec),
		.raddr (ram_raddr),
		.rdata (rd_rec)
	);

	always_comb begin
		case (cmd.rd_sel)
			krs_pkg::RD_TOP:   ram_raddr = IDX_W'(fill_q - 1'b1);
			krs_pkg::RD_NEXT:  ram_raddr = idx_q - 1'b1;
			krs_pkg::RD_ABOVE: ram_raddr = idx_q + 1'b1;
			krs_pkg::RD_SHIFT: ram_raddr = sidx_q + IDX_W'(2);
			default:           ram_raddr = idx_q;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		wr_rec = rd_rec;
		if (cmd.wr_insert) begin
			ram_we = 1'b1;
			ram_waddr = IDX_W'(fill_q);
			wr_rec.id = item_q.order_id;
			wr_rec.quantity = item_q.quantity;
			wr_rec.status = item_q.status_code;
			wr_rec.customer_ref = item_q.customer_ref;
			wr_rec.dish_ref = item_q.dish_ref;
		end else if (cmd.wr_update) begin
			ram_we = 1'b1;
			wr_rec.status = item_q.status_code;
		end else if (cmd.wr_shift) begin
			ram_we = 1'b1;
			ram_waddr = sidx_q;
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.inc_fill) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.dec_fill) begin
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.clr_hit) begin
				hit_q <= 1'b0;
			end else if (cmd.wr_update) begin
				hit_q <= 1'b1;
			end
			if (cmd.load_pend) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.clr_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req_data;
		end
		if (cmd.load_idx) begin
			idx_q <= IDX_W'(fill_q - 1'b1);
		end else if (cmd.dec_idx) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.set_sidx) begin
			sidx_q <= idx_q;
		end else if (cmd.inc_sidx) begin
			sidx_q <= sidx_q + 1'b1;
		end
		if (cmd.code_load) begin
			code_q <= cmd.code;
		end
		if (cmd.load_pend) begin
			pend_q <= rd_rec;
		end
		if (cmd.out_load) begin
			if (cmd.out_sel == krs_pkg::OUT_PEND) begin
				out_q.result_code <= krs_pkg::RC_OK;
				out_q.has_record <= 1'b1;
				out_q.out_id <= pend_q.id;
				out_q.out_quantity <= pend_q.quantity;
				out_q.out_status <= pend_q.status;
				out_q.out_customer_ref <= pend_q.customer_ref;
				out_q.out_dish_ref <= pend_q.dish_ref;
			end else begin
				out_q.result_code <= code_q;
				out_q.has_record <= 1'b0;
				out_q.out_id <= '0;
				out_q.out_quantity <= '0;
				out_q.out_status <= '0;
				out_q.out_customer_ref <= '0;
				out_q.out_dish_ref <= '0;
			end
			out_q.last <= cmd.out_last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	assign sts.action = item_q.action;
	assign sts.empty = (fill_q == '0);
	assign sts.full = (fill_q == CNT_W'(krs_pkg::STACK_DEPTH));
	assign sts.match = (rd_rec.id == item_q.order_id) || (item_q.action == krs_pkg::ACT_LIST);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.at_top = ((CNT_W'(idx_q) + 1'b1) == fill_q);
	assign sts.shift_last = ((CNT_W'(sidx_q) + 1'b1) == fill_q);
	assign sts.hit = hit_q;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free = out_free;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(krs_pkg::STACK_DEPTH))
		else $error("fill count above stack depth");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_insert |-> !sts.full)
		else $error("insert write into a full stack");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_fill |-> !sts.empty)
		else $error("delete from an empty stack");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |-> !cmd.out_load)
		else $error("stalled result beat overwritten");

	a_pend_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_pend && pend_valid_q) |-> (cmd.out_load && cmd.out_sel == krs_pkg::OUT_PEND))
		else $error("held match dropped");

endmodule

@@ hdl/keyed_record_stack.sv @@
// Keyed record stack: up to STACK_DEPTH records, entry 0 at the bottom.
// Request channel (req_valid/req_stall/req_data) takes one command beat:
// insert, delete by id, update status, lookup, list. Response channel
// (rsp_valid/rsp_stall/rsp_data) returns one or more beats per command,
// last set on the final one; action codes five to seven give no beat.
// Timing: one command at a time. Delete, update, lookup and list walk the
// record RAM one entry per cycle from the top, pausing in lookup and list
// while a stalled response beat blocks the next match; delete then moves
// each record above the removed one down one entry to close the gap.
// req_stall is low only while the controller is idle, so the next command
// can enter while the last response beat still waits in the output register.
// A stalled rsp_valid beat holds; the walk pauses on the next match until it
// drains, so a stall never drops or repeats a beat.
// Reset empties the stack and clears any pending response; RAM contents
// are not cleared and are never read before they are written.
module keyed_record_stack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  krs_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output krs_pkg::rsp_t rsp_data
);

	krs_pkg::cmd_t cmd;
	krs_pkg::sts_t sts;

	krs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	krs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
